// ===== design/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int WORD_BITS_DEF = 32;

	typedef struct packed {
		logic accept_in;
		logic run_first;
		logic run_setup;
		logic merge;
		logic emit_init;
		logic emit_read;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic last_accepted;
		logic width_lt_n;
		logic run_done;
		logic pass_done;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

`default_nettype wire

// ===== design/merge_sort_engine.sv =====
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid, in_ready   value, last
// output   out_valid, out_ready sorted_value, final_res, overflow
//
// One word is loaded per cycle. A batch of n words is sorted in ceil(log2 n)
// passes, each opened by a start state, with a setup state before each run pair's
// merge; a final start state precedes emission, which reads then loads each word.
// Reset clears the counters and the output valid; the buffers are not cleared.
// The input is not ready from the word marked last until the final result is
// loaded into the output register; emission stalls on out_valid && !out_ready.

module merge_sort_engine #(
	parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF,
	parameter int WORD_BITS = mse_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic signed [WORD_BITS-1:0] value,
	input  wire logic                        last,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	output logic signed [WORD_BITS-1:0]      sorted_value,
	output logic                             final_res,
	output logic                             overflow,
	output logic                             out_valid,
	input  wire logic                        out_ready
);

	mse_pkg::cmd_t    cmd;
	mse_pkg::status_t sts;

	mse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mse_datapath #(
		.MAX_ITEMS (MAX_ITEMS),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.last         (last),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule

`default_nettype wire

// ===== design/mse_ctrl.sv =====
`default_nettype none

module mse_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mse_pkg::status_t sts,
	output mse_pkg::cmd_t         cmd
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_PASS  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_ERD   = 3'd4;
	localparam logic [2:0] S_EWR   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.accept_in = 1'b1;
				if (sts.last_accepted) begin
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				if (sts.width_lt_n) begin
					cmd.run_first = 1'b1;
					state_d       = S_SETUP;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = S_ERD;
				end
			end
			S_SETUP: begin
				cmd.run_setup = 1'b1;
				state_d       = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				if (sts.run_done) begin
					state_d = sts.pass_done ? S_PASS : S_SETUP;
				end
			end
			S_ERD: begin
				cmd.emit_read = 1'b1;
				state_d       = S_EWR;
			end
			S_EWR: begin
				cmd.emit_load = 1'b1;
				if (sts.out_free) begin
					state_d = sts.emit_last ? S_LOAD : S_ERD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/mse_datapath.sv =====
`default_nettype none

module mse_datapath #(
	parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF,
	parameter int WORD_BITS = mse_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mse_pkg::cmd_t               cmd,
	output mse_pkg::status_t                 sts,
	input  wire logic signed [WORD_BITS-1:0] value,
	input  wire logic                        last,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	output logic signed [WORD_BITS-1:0]      sorted_value,
	output logic                             final_res,
	output logic                             overflow,
	output logic                             out_valid,
	input  wire logic                        out_ready
);

	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS) + 1;

	logic [WORD_BITS-1:0] work_mem  [MAX_ITEMS];
	logic [WORD_BITS-1:0] merge_mem [MAX_ITEMS];

	logic [WORD_BITS-1:0] work_rd_a_q, work_rd_b_q, merge_rd_a_q, merge_rd_b_q;
	logic [CNT_W-1:0]     count_q, width_q, lo_q, mid_q, hi_q, i_q, j_q, k_q, e_q;
	logic                 dropped_q, sel_q;

	logic                 accept;
	logic [CNT_W:0]       lo_w, lo_2w, n_w;
	logic [CNT_W-1:0]     mid_c, hi_c, i_n, j_n, k_n, e_n, ra, rb;
	logic [WORD_BITS-1:0] src_a, src_b, wr_word;
	logic                 take_a;
	logic                 work_we, merge_we;
	logic [ADDR_W-1:0]    work_wa, merge_wa;
	logic [WORD_BITS-1:0] work_wd;
	logic                 out_free;
	logic                 rd_en;

	assign in_ready = cmd.accept_in;
	assign accept   = in_valid && cmd.accept_in;

	assign n_w   = {1'b0, count_q};
	assign lo_w  = {1'b0, lo_q} + {1'b0, width_q};
	assign lo_2w = {1'b0, lo_q} + {width_q, 1'b0};
	assign mid_c = (lo_w < n_w) ? lo_w[CNT_W-1:0] : count_q;
	assign hi_c  = (lo_2w < n_w) ? lo_2w[CNT_W-1:0] : count_q;

	assign src_a = sel_q ? merge_rd_a_q : work_rd_a_q;
	assign src_b = sel_q ? merge_rd_b_q : work_rd_b_q;

	assign take_a  = (i_q < mid_q) &&
		((j_q >= hi_q) || ($signed(src_a) < $signed(src_b)));
	assign wr_word = take_a ? src_a : src_b;
	assign i_n     = i_q + CNT_W'(take_a);
	assign j_n     = j_q + CNT_W'(!take_a);
	assign k_n     = k_q + CNT_W'(1);
	assign e_n     = e_q + CNT_W'(1);

	assign rd_en = cmd.merge || cmd.run_setup || cmd.emit_read;

	always_comb begin
		ra = e_q;
		rb = j_q;
		if (cmd.merge) begin
			ra = i_n;
			rb = j_n;
		end else if (cmd.run_setup) begin
			ra = lo_q;
			rb = mid_c;
		end
	end

	always_comb begin
		work_we  = 1'b0;
		work_wa  = count_q[ADDR_W-1:0];
		work_wd  = value;
		merge_we = 1'b0;
		merge_wa = k_q[ADDR_W-1:0];
		if (accept) begin
			work_we = count_q < CNT_W'(MAX_ITEMS);
		end else if (cmd.merge) begin
			if (sel_q) begin
				work_we = 1'b1;
				work_wa = k_q[ADDR_W-1:0];
				work_wd = wr_word;
			end else begin
				merge_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[work_wa] <= work_wd;
		end
		if (rd_en) begin
			work_rd_a_q <= work_mem[ra[ADDR_W-1:0]];
			work_rd_b_q <= work_mem[rb[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (merge_we) begin
			merge_mem[merge_wa] <= wr_word;
		end
		if (rd_en) begin
			merge_rd_a_q <= merge_mem[ra[ADDR_W-1:0]];
			merge_rd_b_q <= merge_mem[rb[ADDR_W-1:0]];
		end
	end

	assign out_free = !out_valid || out_ready;

	assign sts.last_accepted = accept && last;
	assign sts.width_lt_n    = width_q < count_q;
	assign sts.run_done      = k_n == hi_q;
	assign sts.pass_done     = hi_q == count_q;
	assign sts.out_free      = out_free;
	assign sts.emit_last     = e_n == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			sel_q     <= 1'b0;
			width_q   <= CNT_W'(1);
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			e_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				if (count_q < CNT_W'(MAX_ITEMS)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				if (last) begin
					sel_q   <= 1'b0;
					width_q <= CNT_W'(1);
				end
			end
			if (cmd.run_first) begin
				lo_q <= '0;
			end
			if (cmd.run_setup) begin
				i_q   <= lo_q;
				j_q   <= mid_c;
				k_q   <= lo_q;
				mid_q <= mid_c;
				hi_q  <= hi_c;
			end
			if (cmd.merge) begin
				i_q <= i_n;
				j_q <= j_n;
				k_q <= k_n;
				if (k_n == hi_q) begin
					if (hi_q == count_q) begin
						sel_q   <= !sel_q;
						width_q <= {width_q[CNT_W-2:0], 1'b0};
					end else begin
						lo_q <= hi_q;
					end
				end
			end
			if (cmd.emit_init) begin
				e_q <= '0;
			end
			if (cmd.emit_load && out_free) begin
				out_valid <= 1'b1;
				e_q       <= e_n;
				if (e_n == count_q) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load && out_free) begin
			sorted_value <= src_a;
			final_res    <= e_n == count_q;
			overflow     <= dropped_q;
		end
	end

endmodule

`default_nettype wire
